// ===== hdl/wavhp_pkg.sv =====
// Shared types, constants and control structs for the WAV header parser.
`default_nettype none

package wavhp_pkg;

    // Chunk tags as they appear little-endian in the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte counts of the header sections
    localparam logic [4:0] TAG_BYTES    = 5'd4;
    localparam logic [4:0] HEADER_BYTES = 5'd12;
    localparam logic [4:0] CHDR_BYTES   = 5'd8;
    localparam logic [4:0] FMT_BYTES    = 5'd16;

    // Duration arithmetic
    localparam logic [9:0] MS_PER_S   = 10'd1000;
    localparam int         DIVIDEND_W = 42;   // 32-bit length times 1000
    localparam int         PROD_W     = 47;   // 31-bit rate times 16-bit channels
    localparam int         DIVISOR_W  = 60;   // times 13-bit bytes per sample

    // Result payload width and padded bus width
    localparam int OUT_W      = 114;
    localparam int OUT_BUS_W  = 120;

    // Parser phases, plus the two phases of the duration calculation
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG,
        PH_HEAD,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_CALC,
        PH_WAIT
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_RIFF = 2'd1,
        STAT_NO_DATA  = 2'd2
    } status_t;

    // Which result the datapath loads into the output register
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_NOT_RIFF,
        EMIT_NO_DATA,
        EMIT_DATA
    } emit_t;

    // Duration unit states
    typedef enum logic [1:0] {
        DUR_IDLE,
        DUR_SCALE,
        DUR_DIV
    } dur_state_t;

    // Controller to datapath
    typedef struct packed {
        logic   take;        // byte accepted and belongs to a file
        logic   clear;       // first byte of a file: start from cleared state
        phase_t op;          // phase this byte is processed in
        emit_t  emit;        // load the output register
        logic   calc_start;  // start the duration unit
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic step_end;    // this byte completes the current phase
        logic tag_riff;    // tag including this byte is RIFF
        logic tag_fmt;     // chunk tag is fmt
        logic tag_data;    // chunk tag is data
        logic total_zero;  // padded chunk length is zero
        logic skip_zero;   // nothing left to skip after the fmt body
        logic fmt_seen;    // a full fmt body has been captured
        logic calc_busy;   // duration unit working
        logic out_free;    // output register can take a result this cycle
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/wavhp_dur.sv =====
// Duration unit: two multiply stages and a restoring divider, one quotient bit per cycle.
`default_nettype none

module wavhp_dur import wavhp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] rate,
    input  wire logic [15:0] channels,
    input  wire logic [15:0] bits,
    input  wire logic [31:0] length,
    output logic             busy,
    output logic [31:0]      dur_ms
);

    dur_state_t              state_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DIVISOR_W-1:0]    divisor_reg;
    logic [DIVIDEND_W-1:0]   quot_reg;
    logic [DIVISOR_W:0]      rem_reg;
    logic [5:0]              cnt_reg;
    logic                    zero_reg;

    logic [DIVISOR_W:0]      rem_shift;
    logic                    sub_ok;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg[DIVISOR_W-1:0], quot_reg[DIVIDEND_W-1]};
        sub_ok    = rem_shift >= {1'b0, divisor_reg};
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DUR_IDLE;
        end else begin
            unique case (state_reg)
                DUR_IDLE:  if (start) state_reg <= DUR_SCALE;
                DUR_SCALE: state_reg <= DUR_DIV;
                DUR_DIV:   if (cnt_reg == 6'(DIVIDEND_W - 1)) state_reg <= DUR_IDLE;
                default:   state_reg <= DUR_IDLE;
            endcase
        end
    end

    // Arithmetic registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            DUR_IDLE: begin
                if (start) begin
                    prod_reg <= PROD_W'(rate[30:0]) * PROD_W'(channels);
                    quot_reg <= DIVIDEND_W'(length) * DIVIDEND_W'(MS_PER_S);
                    zero_reg <= rate[31] || (length == 32'd0);
                end
            end
            DUR_SCALE: begin
                divisor_reg <= DIVISOR_W'(prod_reg) * DIVISOR_W'(bits[15:3]);
                rem_reg     <= '0;
                cnt_reg     <= '0;
            end
            DUR_DIV: begin
                rem_reg  <= sub_ok ? rem_shift - {1'b0, divisor_reg} : rem_shift;
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], sub_ok};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != DUR_IDLE);
    assign dur_ms = (zero_reg || divisor_reg == '0) ? 32'd0 : quot_reg[31:0];

endmodule

`default_nettype wire

// ===== hdl/wavhp_dp.sv =====
// Datapath: byte position, tag and length shifters, skip counter, fmt fields, output register.
`default_nettype none

module wavhp_dp import wavhp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [7:0]           s_byte,
    input  wire dp_cmd_t              cmd,
    input  wire logic                 m_tready,
    output dp_stat_t                  stat,
    output logic                      m_tvalid,
    output logic [OUT_BUS_W-1:0]      m_tdata
);

    logic [4:0]  pos_reg,  pos_next;
    logic [31:0] tag_reg,  tag_next;
    logic [31:0] len_reg,  len_next;
    logic [32:0] skip_reg, skip_next;
    logic [15:0] fmt_reg,  fmt_next;
    logic [15:0] ch_reg,   ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_reg;

    // Values the byte starts from: cleared on the first byte of a file
    logic [4:0]  pos_b;
    logic [31:0] tag_b, len_b, rate_b;
    logic [32:0] skip_b;
    logic [15:0] fmt_b, ch_b, bits_b;
    logic        seen_b;

    logic [4:0]  pos_inc;
    logic [31:0] tag_shift, len_shift;
    logic [32:0] total, skip_dec;
    logic [31:0] dur_ms;
    logic        dur_busy;

    // Next-state logic for the parse registers and phase status
    always_comb begin
        pos_b  = cmd.clear ? '0 : pos_reg;
        tag_b  = cmd.clear ? '0 : tag_reg;
        len_b  = cmd.clear ? '0 : len_reg;
        skip_b = cmd.clear ? '0 : skip_reg;
        fmt_b  = cmd.clear ? '0 : fmt_reg;
        ch_b   = cmd.clear ? '0 : ch_reg;
        rate_b = cmd.clear ? '0 : rate_reg;
        bits_b = cmd.clear ? '0 : bits_reg;
        seen_b = cmd.clear ? 1'b0 : seen_reg;

        pos_inc   = pos_b + 5'd1;
        tag_shift = {s_byte, tag_b[31:8]};
        len_shift = {s_byte, len_b[31:8]};
        total     = {1'b0, len_shift} + {32'd0, len_shift[0]};
        skip_dec  = (skip_b != '0) ? skip_b - 33'd1 : skip_b;

        pos_next  = pos_b;
        tag_next  = tag_b;
        len_next  = len_b;
        skip_next = skip_b;
        fmt_next  = fmt_b;
        ch_next   = ch_b;
        rate_next = rate_b;
        bits_next = bits_b;
        seen_next = seen_b;

        stat            = '0;
        stat.tag_riff   = (tag_shift == TAG_RIFF);
        stat.tag_fmt    = (tag_b == TAG_FMT);
        stat.tag_data   = (tag_b == TAG_DATA);
        stat.total_zero = (total == '0);
        stat.skip_zero  = (skip_b == '0);
        stat.fmt_seen   = seen_reg;
        stat.calc_busy  = dur_busy;
        stat.out_free   = !out_valid_reg || m_tready;

        unique case (cmd.op)
            PH_TAG: begin
                tag_next      = tag_shift;
                pos_next      = pos_inc;
                stat.step_end = (pos_inc == TAG_BYTES);
            end
            PH_HEAD: begin
                stat.step_end = (pos_inc >= HEADER_BYTES);
                pos_next      = stat.step_end ? '0 : pos_inc;
            end
            PH_CHDR: begin
                // tag bytes first, then length bytes
                if (pos_b < TAG_BYTES) begin
                    tag_next = tag_shift;
                end else begin
                    len_next = len_shift;
                end
                stat.step_end = (pos_inc == CHDR_BYTES);
                pos_next      = stat.step_end ? '0 : pos_inc;
                if (stat.step_end) begin
                    if (tag_b == TAG_FMT) begin
                        // only the part of the fmt chunk past its 16 bytes is skipped
                        skip_next = (total >= 33'(FMT_BYTES)) ? total - 33'(FMT_BYTES) : '0;
                        fmt_next  = '0;
                        ch_next   = '0;
                        rate_next = '0;
                        bits_next = '0;
                    end else begin
                        skip_next = total;
                    end
                end
            end
            PH_FMT: begin
                unique case (pos_b[3:0])
                    4'd0:    fmt_next[7:0]    = s_byte;
                    4'd1:    fmt_next[15:8]   = s_byte;
                    4'd2:    ch_next[7:0]     = s_byte;
                    4'd3:    ch_next[15:8]    = s_byte;
                    4'd4:    rate_next[7:0]   = s_byte;
                    4'd5:    rate_next[15:8]  = s_byte;
                    4'd6:    rate_next[23:16] = s_byte;
                    4'd7:    rate_next[31:24] = s_byte;
                    4'd14:   bits_next[7:0]   = s_byte;
                    4'd15:   bits_next[15:8]  = s_byte;
                    default: ;
                endcase
                stat.step_end = (pos_inc >= FMT_BYTES);
                pos_next      = stat.step_end ? '0 : pos_inc;
                if (stat.step_end) begin
                    seen_next = 1'b1;
                end
            end
            PH_SKIP: begin
                skip_next     = skip_dec;
                stat.step_end = (skip_dec == '0);
                if (stat.step_end) begin
                    pos_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Parse registers, written once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            tag_reg  <= '0;
            len_reg  <= '0;
            skip_reg <= '0;
            fmt_reg  <= '0;
            ch_reg   <= '0;
            rate_reg <= '0;
            bits_reg <= '0;
            seen_reg <= 1'b0;
        end else if (cmd.take) begin
            pos_reg  <= pos_next;
            tag_reg  <= tag_next;
            len_reg  <= len_next;
            skip_reg <= skip_next;
            fmt_reg  <= fmt_next;
            ch_reg   <= ch_next;
            rate_reg <= rate_next;
            bits_reg <= bits_next;
            seen_reg <= seen_next;
        end
    end

    // Duration of the data chunk
    wavhp_dur u_dur (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.calc_start),
        .rate     (rate_reg),
        .channels (ch_reg),
        .bits     (bits_reg),
        .length   (len_reg),
        .busy     (dur_busy),
        .dur_ms   (dur_ms)
    );

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit != EMIT_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: {duration, bits, rate, channels, format, status}
    always_ff @(posedge aclk) begin
        unique case (cmd.emit)
            EMIT_NOT_RIFF: out_reg <= {112'd0, STAT_NOT_RIFF};
            EMIT_NO_DATA: begin
                if (seen_next) begin
                    out_reg <= {32'd0, bits_next, rate_next, ch_next, fmt_next, STAT_NO_DATA};
                end else begin
                    out_reg <= {112'd0, STAT_NO_DATA};
                end
            end
            EMIT_DATA: out_reg <= {dur_ms, bits_reg, rate_reg, ch_reg, fmt_reg, STAT_OK};
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_BUS_W - OUT_W)'(0), out_reg};

endmodule

`default_nettype wire

// ===== hdl/wavhp_ctrl.sv =====
// Controller: parse phase state machine, input handshake and result sequencing.
`default_nettype none

module wavhp_ctrl import wavhp_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_tuser,
    input  wire logic     s_tlast,
    input  wire dp_stat_t stat,
    output logic          s_tready,
    output dp_cmd_t       cmd
);

    phase_t state_reg, state_next;
    phase_t eff;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.op     = PH_IDLE;
        cmd.emit   = EMIT_NONE;
        // a first byte restarts the parser from any parse phase
        eff        = s_tuser ? PH_TAG : state_reg;

        unique case (state_reg)
            PH_CALC: begin
                cmd.calc_start = 1'b1;
                state_next     = PH_WAIT;
            end
            PH_WAIT: begin
                if (!stat.calc_busy && stat.out_free) begin
                    cmd.emit   = EMIT_DATA;
                    state_next = PH_IDLE;
                end
            end
            default: begin
                s_tready  = stat.out_free;
                cmd.op    = eff;
                cmd.clear = s_tuser;
                if (s_tvalid && stat.out_free && eff != PH_IDLE) begin
                    cmd.take   = 1'b1;
                    state_next = eff;
                    unique case (eff)
                        PH_TAG: begin
                            if (stat.step_end) begin
                                if (!stat.tag_riff) begin
                                    cmd.emit   = EMIT_NOT_RIFF;
                                    state_next = PH_IDLE;
                                end else begin
                                    state_next = PH_HEAD;
                                end
                            end else if (s_tlast) begin
                                // file ended inside the tag
                                cmd.emit   = EMIT_NOT_RIFF;
                                state_next = PH_IDLE;
                            end
                        end
                        PH_HEAD: begin
                            if (stat.step_end) state_next = PH_CHDR;
                        end
                        PH_CHDR: begin
                            if (stat.step_end) begin
                                if (stat.tag_fmt) begin
                                    state_next = PH_FMT;
                                end else if (stat.tag_data && stat.fmt_seen) begin
                                    state_next = PH_CALC;
                                end else begin
                                    state_next = stat.total_zero ? PH_CHDR : PH_SKIP;
                                end
                            end
                        end
                        PH_FMT: begin
                            if (stat.step_end) begin
                                state_next = stat.skip_zero ? PH_CHDR : PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            if (stat.step_end) state_next = PH_CHDR;
                        end
                        default: ;
                    endcase
                    // end of file before the data chunk
                    if (s_tlast && cmd.emit == EMIT_NONE && state_next != PH_CALC) begin
                        cmd.emit   = EMIT_NO_DATA;
                        state_next = PH_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/wav_header_parser_top.sv =====
// Top level of the WAV header parser: controller plus datapath.
`default_nettype none

// Takes a WAV file one byte per request (s_tuser marks the first byte, s_tlast the last)
// and returns at most one result per file on m_tdata: status, the fmt chunk's format,
// channels, sample rate and bits, and the data chunk's duration in milliseconds. While
// parsing, and when not held off as below, the block takes one byte per cycle. The byte
// that completes the data chunk header starts the duration unit: a start step that also
// does the first multiply, a step for the second multiply, 42 divide steps (one quotient
// bit per cycle) and a step to load the result. Input is held off until that result is
// loaded. Input is also held off while a finished result waits to be taken and a new one
// could not be stored. Bytes after a result, or before a first byte, are taken and
// ignored.
module wav_header_parser_top import wavhp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tuser,   // [0] first_byte
    input  wire logic                 s_tlast,   // last_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [17:2] audio_format, [33:18] channel_count, [65:34] samp_rate,
    // [81:66] sample_bits, [113:82] duration_msec, [119:114] zero
    output logic [OUT_BUS_W-1:0]      m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wavhp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    wavhp_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_byte   (s_tdata),
        .cmd      (cmd),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/wavhp_chk.sv =====
// Port-level checker for the WAV header parser, bound to the top level.
`default_nettype none

module wavhp_chk import wavhp_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_BUS_W-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No new byte is taken while a result is stuck
    a_in_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input ready while result stalled");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STAT_OK || m_tdata[1:0] == STAT_NOT_RIFF ||
                      m_tdata[1:0] == STAT_NO_DATA))
        else $error("undefined status code");

    // A file that is not RIFF reports nothing else
    a_not_riff_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == STAT_NOT_RIFF |-> m_tdata[OUT_BUS_W-1:2] == '0)
        else $error("not-RIFF result carries fields");

    // Only a found data chunk has a duration
    a_no_data_dur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == STAT_NO_DATA |-> m_tdata[113:82] == 32'd0)
        else $error("duration without data chunk");

endmodule

bind wav_header_parser_top wavhp_chk u_chk (.*);

`default_nettype wire

// ===== sim/wav_header_checker.sv =====
// Checker for the WAV header parser: predicts each report from the byte stream and compares.
`timescale 1ns / 1ps

module wav_header_checker import wavhp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
    input  wire logic                 s_tuser,   // [0] first_byte
    input  wire logic                 s_tlast,   // last_byte
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [1:0] status, [17:2] audio_format, [33:18] channel_count, [65:34] samp_rate,
    // [81:66] sample_bits, [113:82] duration_msec, [119:114] zero
    input  wire logic [OUT_BUS_W-1:0] m_tdata,
    output int                        error_count,
    output int                        reports_pending
);

    typedef struct {
        status_t     status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] samp_rate;
        logic [15:0] sample_bits;
        logic [31:0] duration_msec;
    } wav_report_t;

    wav_report_t expected_reports[$];
    wav_report_t want;

    // Parser state mirrored from the byte stream
    phase_t      phase;
    logic [4:0]  pos;
    logic [31:0] tag;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic [63:0] fmt_lo;   // fmt body bytes 0..7
    logic [63:0] fmt_hi;   // fmt body bytes 8..15
    bit          fmt_seen;
    bit          reported;

    task automatic log_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
    endtask

    task automatic clear_file_state();
        phase     = PH_IDLE;
        pos       = '0;
        tag       = '0;
        chunk_len = '0;
        skip_left = '0;
        fmt_lo    = '0;
        fmt_hi    = '0;
        fmt_seen  = 0;
        reported  = 0;
    endtask

    // Build one report from the captured fmt fields and queue it
    task automatic queue_report(input status_t st, input bit with_fmt, input bit with_dur);
        wav_report_t r;
        logic [63:0] divisor;
        logic [63:0] quot;
        r.status        = st;
        r.audio_format  = with_fmt ? fmt_lo[15:0]  : 16'd0;
        r.channel_count = with_fmt ? fmt_lo[31:16] : 16'd0;
        r.samp_rate     = with_fmt ? fmt_lo[63:32] : 32'd0;
        r.sample_bits   = with_fmt ? fmt_hi[63:48] : 16'd0;
        r.duration_msec = 32'd0;
        if (with_dur && !r.samp_rate[31] && r.samp_rate != 0 && chunk_len != 0) begin
            divisor = {32'd0, r.samp_rate} * {48'd0, r.channel_count}
                    * {51'd0, r.sample_bits[15:3]};
            if (divisor != 0) begin
                quot = ({32'd0, chunk_len} * 64'd1000) / divisor;
                r.duration_msec = quot[31:0];
            end
        end
        expected_reports.push_back(r);
        reported = 1;
        phase    = PH_IDLE;
    endtask

    // Advance the mirrored parser by one accepted byte
    task automatic predict_header_byte(input logic [7:0] b, input bit first, input bit last);
        logic [32:0] total;
        if (first) begin
            clear_file_state();
            phase = PH_TAG;
        end
        if (phase == PH_IDLE)
            return;

        case (phase)
            PH_TAG: begin
                tag = {b, tag[31:8]};
                pos++;
                if (pos == TAG_BYTES) begin
                    if (tag != TAG_RIFF) begin
                        queue_report(STAT_NOT_RIFF, 0, 0);
                        return;
                    end
                    phase = PH_HEAD;
                end else if (last) begin
                    // tag cut short
                    queue_report(STAT_NOT_RIFF, 0, 0);
                    return;
                end
            end
            PH_HEAD: begin
                pos++;
                if (pos >= HEADER_BYTES) begin
                    pos   = '0;
                    phase = PH_CHDR;
                end
            end
            PH_CHDR: begin
                if (pos < 5'd4)
                    tag = {b, tag[31:8]};
                else
                    chunk_len = {b, chunk_len[31:8]};
                pos++;
                if (pos == CHDR_BYTES) begin
                    total = {1'b0, chunk_len} + chunk_len[0];
                    pos   = '0;
                    if (tag == TAG_FMT) begin
                        skip_left = (total >= 33'd16) ? total - 33'd16 : 33'd0;
                        fmt_lo    = '0;
                        fmt_hi    = '0;
                        phase     = PH_FMT;
                    end else if (tag == TAG_DATA && fmt_seen) begin
                        queue_report(STAT_OK, 1, 1);
                        return;
                    end else begin
                        skip_left = total;
                        phase     = (total != 0) ? PH_SKIP : PH_CHDR;
                    end
                end
            end
            PH_FMT: begin
                if (pos[3])
                    fmt_hi[{pos[2:0], 3'b000} +: 8] = b;
                else
                    fmt_lo[{pos[2:0], 3'b000} +: 8] = b;
                pos++;
                if (pos >= FMT_BYTES) begin
                    pos      = '0;
                    fmt_seen = 1;
                    phase    = (skip_left != 0) ? PH_SKIP : PH_CHDR;
                end
            end
            default: begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0) begin
                    pos   = '0;
                    phase = PH_CHDR;
                end
            end
        endcase

        if (last && !reported)
            queue_report(STAT_NO_DATA, fmt_seen, 0);
    endtask

    // Results are checked before the byte of the same edge is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_file_state();
            expected_reports.delete();
            error_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    log_mismatch($sformatf("unexpected result 0x%0h", m_tdata));
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status",        m_tdata[1:0],   want.status);
                    check_field("audio_format",  m_tdata[17:2],  want.audio_format);
                    check_field("channel_count", m_tdata[33:18], want.channel_count);
                    check_field("samp_rate",     m_tdata[65:34], want.samp_rate);
                    check_field("sample_bits",   m_tdata[81:66], want.sample_bits);
                    check_field("duration_msec", m_tdata[113:82], want.duration_msec);
                    check_field("pad",           m_tdata[OUT_BUS_W-1:OUT_W], 32'd0);
                end
            end
            if (s_tvalid && s_tready)
                predict_header_byte(s_tdata, s_tuser, s_tlast);
        end
        reports_pending = expected_reports.size();
    end

endmodule

// ===== sim/tb_wav_header_parser_top.sv =====
// Testbench top for the WAV header parser: byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_wav_header_parser_top;
    import wavhp_pkg::*;

    localparam int STALL_LIMIT  = 3000;   // cycles with no request moving on either side
    localparam int RANDOM_BYTES = 1100;   // directed files add roughly 500 more
    localparam int SETTLE       = 100;    // covers the duration unit and the output register

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'd0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BUS_W-1:0] m_tdata;

    int   error_count;
    int   reports_pending;
    bit   quiet_stretch = 0;
    int   bytes_sent    = 0;
    int   stall_cycles  = 0;

    logic [7:0] file_bytes[$];

    wav_header_parser_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wav_header_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .error_count     (error_count),
        .reports_pending (reports_pending)
    );

    always #2 aclk = ~aclk;

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 36);
    end

    // Watchdog on requests moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One byte request; starts and ends at a rising edge
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
        bit hit;
        while (!quiet_stretch && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        hit = 0;
        while (!hit) begin
            @(negedge aclk);
            hit = s_tready;
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_file(input bit with_last);
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0, with_last && (i == file_bytes.size() - 1));
        file_bytes.delete();
    endtask

    task automatic add_u16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic add_u32(input logic [31:0] v);
        add_u16(v[15:0]);
        add_u16(v[31:16]);
    endtask

    // RIFF tag, size and form type (the last two are not looked at)
    task automatic add_riff_head();
        add_u32(TAG_RIFF);
        add_u32($urandom);
        add_u32($urandom);
    endtask

    task automatic add_chunk(input logic [31:0] tag, input logic [31:0] len);
        add_u32(tag);
        add_u32(len);
        repeat (len + len[0]) file_bytes.push_back(8'($urandom));
    endtask

    // The 16 body bytes always follow; the padded rest only when longer than 16
    task automatic add_fmt(input logic [31:0] len, input logic [15:0] fmt,
                           input logic [15:0] ch, input logic [31:0] rate,
                           input logic [15:0] bits);
        logic [32:0] padded;
        add_u32(TAG_FMT);
        add_u32(len);
        add_u16(fmt);
        add_u16(ch);
        add_u32(rate);
        add_u32($urandom);
        add_u16(16'($urandom));
        add_u16(bits);
        padded = {1'b0, len} + len[0];
        if (padded > 33'd16)
            repeat (padded - 33'd16) file_bytes.push_back(8'($urandom));
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (reports_pending != 0);
        @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        int          random_start;
        int          file_no;
        int          ending;
        int          cut;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] ch;
        logic [15:0] fmt;
        logic [31:0] fmt_len;
        logic [31:0] data_len;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed cases ----
        // bytes with no file started are ignored, even with last set
        send_byte(8'hA5, 0, 0);
        send_byte(8'h00, 0, 1);
        // one-byte file
        file_bytes.push_back(8'h00);
        send_file(1);
        // tag cut short after three bytes
        add_u32(TAG_RIFF);
        void'(file_bytes.pop_back());
        send_file(1);
        // wrong tag
        add_u32(32'hFFFF_FFFF);
        send_file(1);
        // abandoned file, restarted by the next first byte
        add_riff_head();
        add_chunk(32'h5453_494C, 2);
        send_file(0);
        // plain PCM: 44.1 kHz stereo 16 bit, one second, empty chunk first, tail ignored
        add_riff_head();
        add_chunk(32'h0000_0000, 0);
        add_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
        add_u32(TAG_DATA);
        add_u32(32'd176400);
        add_u32($urandom);
        send_file(1);
        // all-ones fmt fields: rate top bit set gives zero duration
        add_riff_head();
        add_fmt(16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_u32(TAG_DATA);
        add_u32(32'hFFFF_FFFF);
        send_file(1);
        // under 8 bits per sample: zero divisor
        add_riff_head();
        add_fmt(16, 16'd1, 16'd1, 32'd8000, 16'd7);
        add_u32(TAG_DATA);
        add_u32(32'd1000);
        send_file(1);
        // zero rate
        add_riff_head();
        add_fmt(16, 16'd1, 16'd2, 32'd0, 16'd16);
        add_u32(TAG_DATA);
        add_u32(32'd1000);
        send_file(1);
        // zero data length
        add_riff_head();
        add_fmt(16, 16'd1, 16'd2, 32'd48000, 16'd16);
        add_u32(TAG_DATA);
        add_u32(32'd0);
        send_file(1);
        // largest duration, truncated to 32 bits
        add_riff_head();
        add_fmt(16, 16'd1, 16'd1, 32'd1, 16'd8);
        add_u32(TAG_DATA);
        add_u32(32'hFFFF_FFFF);
        send_file(1);
        // data before fmt, odd chunk, short fmt, repeated fmt, end on the data header
        add_riff_head();
        add_chunk(TAG_DATA, 3);
        add_chunk(32'h5453_494C, 5);
        add_fmt(10, 16'd3, 16'd1, 32'd8000, 16'd32);
        add_fmt(16, 16'd1, 16'd6, 32'd96000, 16'd24);
        add_u32(TAG_DATA);
        add_u32(32'd5000);
        send_file(1);
        // odd fmt with padded remainder, then end: no data chunk, fields kept
        add_riff_head();
        add_fmt(21, 16'hFFFE, 16'd2, 32'd22050, 16'd8);
        send_file(1);
        // end inside the fmt body: no fields
        add_riff_head();
        add_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
        repeat (5) void'(file_bytes.pop_back());
        send_file(1);

        // pause until every report has come back
        wait_drained(SETTLE);

        // ---- random files ----
        random_start = bytes_sent;
        file_no      = 0;
        while ((bytes_sent - random_start) < RANDOM_BYTES) begin
            quiet_stretch = (file_no >= 4 && file_no < 14);
            if (file_no == 16)
                wait_drained(SETTLE);

            // stray bytes between files
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom), 0, $urandom_range(0, 3) == 0);

            case ($urandom_range(0, 99)) inside
                [0:7]: begin
                    // short file, often a prefix of the tag
                    if ($urandom_range(0, 1)) begin
                        add_u32(TAG_RIFF);
                        repeat ($urandom_range(1, 3)) void'(file_bytes.pop_back());
                    end else begin
                        repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
                    end
                    send_file(1);
                end
                [8:15]: begin
                    // tag with one bit wrong
                    add_u32(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
                    repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
                    send_file(1);
                end
                default: begin
                    add_riff_head();
                    repeat ($urandom_range(0, 2))
                        add_chunk($urandom, $urandom_range(0, 9));
                    if ($urandom_range(0, 99) < 15)
                        add_chunk(TAG_DATA, $urandom_range(0, 9));

                    fmt = ($urandom_range(0, 9) < 7) ? 16'd1 : 16'($urandom);
                    ch  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(1, 8));
                    case ($urandom_range(0, 6))
                        0: rate = 32'd8000;
                        1: rate = 32'd44100;
                        2: rate = 32'd48000;
                        3: rate = $urandom;
                        4: rate = {1'b1, 31'($urandom)};
                        5: rate = $urandom_range(0, 3);
                        default: rate = $urandom_range(1, 200000);
                    endcase
                    case ($urandom_range(0, 4))
                        0: bits = 16'd8;
                        1: bits = 16'd16;
                        2: bits = 16'd24;
                        3: bits = 16'($urandom);
                        default: bits = 16'($urandom_range(0, 40));
                    endcase
                    fmt_len = ($urandom_range(0, 9) < 7) ? 32'd16 : $urandom_range(0, 40);
                    add_fmt(fmt_len, fmt, ch, rate, bits);
                    if ($urandom_range(0, 9) == 0)
                        add_chunk($urandom, $urandom_range(0, 5));
                    if ($urandom_range(0, 9) == 0)
                        add_fmt(16, 16'($urandom), 16'($urandom_range(1, 4)), $urandom,
                                16'($urandom_range(8, 32)));

                    case ($urandom_range(0, 3))
                        0: data_len = 32'd0;
                        1: data_len = $urandom;
                        default: data_len = $urandom_range(1, 2000000);
                    endcase
                    add_u32(TAG_DATA);
                    add_u32(data_len);

                    ending = $urandom_range(0, 9);
                    if (ending == 2) begin
                        // last flag on the byte that completes the data header
                        send_file(1);
                    end else if (ending == 0) begin
                        // file ends early at a random byte
                        cut = $urandom_range(1, file_bytes.size() - 1);
                        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                        send_file(1);
                    end else begin
                        repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
                        // ending 1 leaves the file open for the next one to restart
                        send_file(ending != 1);
                    end
                end
            endcase
            file_no++;
        end
        quiet_stretch = 0;

        wait_drained(SETTLE);
        if (error_count == 0 && reports_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
